FILE: sv/pd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_pkg: shared definitions for the positional deque
// capacity, field widths, opcodes and the decoded operation passed to the cells
// ----------------------------------------------------------------------------
package pd_pkg;

  localparam int CAPACITY    = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 32;
  localparam int SLOT_W      = 8;
  localparam int OPCODE_W    = 3;
  localparam int COUNT_OUT_W = 6;
  localparam int CMP_W       = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT_AT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_REMOVE_AT  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd6;

  typedef logic signed [KEY_W-1:0] key_t;

  // decoded operation for one accepted transaction
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count_next;
    logic             empty_err;
    logic             full_err;
  } pd_op_t;

endpackage

FILE: sv/pd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_ctrl: opcode decode and occupancy count
// resolves the target position and the error flags for each transaction
// ----------------------------------------------------------------------------
module pd_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [pd_pkg::OPCODE_W-1:0] opcode,
  input  logic [pd_pkg::SLOT_W-1:0]   slot,
  output pd_pkg::pd_op_t              op
);
  import pd_pkg::*;

  logic [CNT_W-1:0] occupancy;
  logic [CMP_W-1:0] slot_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic             empty;
  pd_op_t           dec;

  assign slot_ext = CMP_W'(slot);
  assign cnt_ext  = CMP_W'(occupancy);
  assign full     = (occupancy == CNT_W'(CAPACITY));
  assign empty    = (occupancy == '0);

  always_comb begin
    dec            = '0;
    dec.count_next = occupancy;
    unique case (opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        if (full) begin
          dec.full_err = 1'b1;
        end else begin
          dec.insert     = 1'b1;
          dec.count_next = occupancy + CNT_W'(1);
          if (opcode == OP_PUSH_FRONT) begin
            dec.pos = '0;
          end else if (opcode == OP_PUSH_BACK || slot_ext >= cnt_ext) begin
            dec.pos = IDX_W'(occupancy);
          end else begin
            dec.pos = IDX_W'(slot);
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
        if (empty) begin
          dec.empty_err = 1'b1;
        end else begin
          dec.remove     = 1'b1;
          dec.count_next = occupancy - CNT_W'(1);
          if (opcode == OP_POP_FRONT || (opcode == OP_REMOVE_AT && slot == '0)) begin
            dec.pos = '0;
          end else if (opcode == OP_POP_BACK || slot_ext >= cnt_ext - CMP_W'(1)) begin
            dec.pos = IDX_W'(occupancy - CNT_W'(1));
          end else begin
            dec.pos = IDX_W'(slot);
          end
        end
      end
      OP_CLEAR: begin
        dec.count_next = '0;
      end
      default: begin
        dec.count_next = occupancy;
      end
    endcase
  end

  // cells only move on an accepted transaction
  always_comb begin
    op        = dec;
    op.insert = dec.insert & accept;
    op.remove = dec.remove & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (accept) begin
      occupancy <= dec.count_next;
    end
  end

endmodule

FILE: sv/pd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_cell: one key slot of the shifting row
// holds, loads the new key, or takes a neighbor's key each cycle
// ----------------------------------------------------------------------------
module pd_cell (
  input  logic                     clk,
  input  pd_pkg::pd_op_t           op,
  input  logic [pd_pkg::IDX_W-1:0] index,
  input  pd_pkg::key_t             new_key,
  input  pd_pkg::key_t             left_key,
  input  pd_pkg::key_t             right_key,
  output pd_pkg::key_t             key,
  output pd_pkg::key_t             tap_key
);
  import pd_pkg::*;

  key_t key_next;

  always_comb begin
    key_next = key;
    if (op.insert) begin
      if (index > op.pos) begin
        key_next = left_key;
      end else if (index == op.pos) begin
        key_next = new_key;
      end
    end else if (op.remove && index >= op.pos) begin
      key_next = right_key;
    end
  end

  // contributes its key to the removal read only at the target position
  assign tap_key = (index == op.pos) ? key : '0;

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

FILE: sv/positional_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_deque: bounded deque of signed keys with indexed insert/remove
// a row of shifting cells holds the keys front to back; one result per
// transaction reports the removed key, the new count and error flags
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  input   | in_valid / in_stall     | opcode, new_key, slot
//  output  | out_valid / out_stall   | removed_key, entry_count, empty_error,
//          |                         | full_error
//
//  one transaction per cycle while not stalled: every cell shifts left, shifts
//  right or holds in the same cycle, and the result lands in the output
//  register the next edge; the output register decouples the sides; input
//  stalls only while a result is held there and the output side stalls
//  reset clears the count and the output valid; key cells are not reset
// ----------------------------------------------------------------------------
module positional_deque (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pd_pkg::OPCODE_W-1:0] opcode,
  input  pd_pkg::key_t                new_key,
  input  logic [pd_pkg::SLOT_W-1:0]   slot,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pd_pkg::key_t                removed_key,
  output logic [pd_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic                        empty_error,
  output logic                        full_error
);
  import pd_pkg::*;

  logic   accept;
  pd_op_t op;
  key_t   keys [CAPACITY];
  key_t   taps [CAPACITY];
  key_t   tap_or;

  // take a new transaction unless a result is stuck in the output register
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  pd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (opcode),
    .slot   (slot),
    .op     (op)
  );

  // row of cells, index 0 is the front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t left_key;
    key_t right_key;

    if (i == 0) begin : g_first
      assign left_key = new_key;
    end else begin : g_inner_left
      assign left_key = keys[i-1];
    end

    // the last cell has no right neighbor; its content is stale after a removal
    if (i == CAPACITY - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner_right
      assign right_key = keys[i+1];
    end

    pd_cell u_cell (
      .clk       (clk),
      .op        (op),
      .index     (IDX_W'(i)),
      .new_key   (new_key),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (keys[i]),
      .tap_key   (taps[i])
    );
  end

  // only the target cell drives a nonzero tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_key <= op.remove ? tap_or : '0;
      entry_count <= COUNT_OUT_W'(op.count_next);
      empty_error <= op.empty_err;
      full_error  <= op.full_err;
    end
  end

endmodule

FILE: test/positional_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_deque_tb: self-checking regression for the positional deque
// a directed table covers empty and full stores, both ends, indexed
// insert/remove and clear, then constrained fill/drain traffic runs against
// an in-bench deque predictor while both channels idle and stall at random
// ----------------------------------------------------------------------------
module positional_deque_tb;
  import pd_pkg::*;

  // opcode 7 is unused by the block and must behave as a no-op
  localparam logic [OPCODE_W-1:0] OP_NOP = 3'd7;

  localparam int RANDOM_TXNS   = 1050;
  localparam int HOLD_CYCLES   = 120;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_AT_A     = 250;
  localparam int HOLD_AT_B     = 700;
  localparam int DRAIN_AT      = 500;
  localparam int MAX_REPORTS   = 10;

  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  localparam logic [OPCODE_W-1:0] INSERT_OPS [3] = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT};
  localparam logic [OPCODE_W-1:0] REMOVE_OPS [3] = '{OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT};
  localparam key_t EDGE_KEYS [4] = '{KEY_MAX, KEY_MIN, 32'sd0, -32'sd1};

  // one result as seen on the output channel
  typedef struct packed {
    key_t                   key;
    logic [COUNT_OUT_W-1:0] count;
    logic                   empty_err;
    logic                   full_err;
  } deque_res_t;

  // directed stimulus row; fixed rows carry a hand-written expectation
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    key_t                key;
    logic [SLOT_W-1:0]   slot;
    int                  reps;
    logic                fixed;
    deque_res_t          res;
  } dir_row_t;

  localparam deque_res_t ZERO_RES  = '0;
  localparam deque_res_t EMPTY_RES = '{32'sd0, 6'd0, 1'b1, 1'b0};
  localparam deque_res_t FULL_RES  = '{32'sd0, COUNT_OUT_W'(CAPACITY), 1'b0, 1'b1};

  localparam int DIR_ROWS = 32;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // removals and no-op on the store right after reset
    '{OP_POP_FRONT,  32'sd0,          8'd0,   1,        1'b1, EMPTY_RES},
    '{OP_POP_BACK,   32'sd0,          8'd255, 1,        1'b1, EMPTY_RES},
    '{OP_REMOVE_AT,  32'sd0,          8'd255, 1,        1'b1, EMPTY_RES},
    '{OP_REMOVE_AT,  32'sd0,          8'd0,   1,        1'b1, EMPTY_RES},
    '{OP_NOP,        KEY_MAX,         8'd255, 1,        1'b1, ZERO_RES},
    // build a short list from both ends and by position
    '{OP_PUSH_BACK,  KEY_MAX,         8'd0,   1,        1'b1, '{32'sd0, 6'd1, 1'b0, 1'b0}},
    '{OP_PUSH_FRONT, KEY_MIN,         8'd255, 1,        1'b1, '{32'sd0, 6'd2, 1'b0, 1'b0}},
    '{OP_INSERT_AT,  -32'sd1,         8'd0,   1,        1'b1, '{32'sd0, 6'd3, 1'b0, 1'b0}},
    '{OP_INSERT_AT,  32'sh5A5A_5A5A,  8'd255, 1,        1'b1, '{32'sd0, 6'd4, 1'b0, 1'b0}},
    '{OP_INSERT_AT,  32'sh1234_5678,  8'd2,   1,        1'b1, '{32'sd0, 6'd5, 1'b0, 1'b0}},
    '{OP_INSERT_AT,  32'shA5A5_A5A5,  8'd5,   1,        1'b1, '{32'sd0, 6'd6, 1'b0, 1'b0}},
    // take keys out from the front, the back, the middle
    '{OP_REMOVE_AT,  32'sd0,          8'd0,   1,        1'b0, ZERO_RES},
    '{OP_REMOVE_AT,  32'sd0,          8'd4,   1,        1'b0, ZERO_RES},
    '{OP_REMOVE_AT,  32'sd0,          8'd1,   1,        1'b0, ZERO_RES},
    '{OP_POP_BACK,   32'sd0,          8'd0,   1,        1'b0, ZERO_RES},
    '{OP_POP_FRONT,  32'sd0,          8'd0,   1,        1'b0, ZERO_RES},
    '{OP_REMOVE_AT,  32'sd0,          8'd200, 1,        1'b0, ZERO_RES},
    '{OP_POP_BACK,   32'sd0,          8'd0,   1,        1'b1, EMPTY_RES},
    // single key removed from the opposite end, then the head must be gone
    '{OP_PUSH_FRONT, 32'sh0F0F_0F0F,  8'd0,   1,        1'b1, '{32'sd0, 6'd1, 1'b0, 1'b0}},
    '{OP_POP_BACK,   32'sd0,          8'd0,   1,        1'b0, ZERO_RES},
    '{OP_PUSH_BACK,  32'sh1111_1111,  8'd0,   1,        1'b1, '{32'sd0, 6'd1, 1'b0, 1'b0}},
    '{OP_POP_FRONT,  32'sd0,          8'd0,   1,        1'b0, ZERO_RES},
    '{OP_REMOVE_AT,  32'sd0,          8'd0,   1,        1'b1, EMPTY_RES},
    // fill to capacity, then every insert flavor must be dropped
    '{OP_PUSH_BACK,  32'sh0000_0100,  8'd0,   CAPACITY, 1'b0, ZERO_RES},
    '{OP_PUSH_FRONT, 32'sh0BAD_0001,  8'd0,   1,        1'b1, FULL_RES},
    '{OP_INSERT_AT,  32'sh0BAD_0002,  8'd7,   1,        1'b1, FULL_RES},
    '{OP_PUSH_BACK,  32'sh0BAD_0003,  8'd255, 1,        1'b1, FULL_RES},
    '{OP_REMOVE_AT,  32'sd0,          8'd31,  1,        1'b0, ZERO_RES},
    // clear a populated store, refill one, clear again
    '{OP_CLEAR,      32'sd0,          8'd0,   1,        1'b1, ZERO_RES},
    '{OP_PUSH_BACK,  32'sd7,          8'd0,   1,        1'b1, '{32'sd0, 6'd1, 1'b0, 1'b0}},
    '{OP_CLEAR,      KEY_MIN,         8'd255, 1,        1'b1, ZERO_RES},
    '{OP_POP_FRONT,  32'sd0,          8'd0,   1,        1'b1, EMPTY_RES}
  };

  // dut ports, all inputs known from time zero
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic [OPCODE_W-1:0]    opcode    = OP_NOP;
  key_t                   new_key   = '0;
  logic [SLOT_W-1:0]      slot      = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  key_t                   removed_key;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   empty_error;
  logic                   full_error;

  // predictor state: the list front to back and its length
  key_t       list_keys [CAPACITY];
  int         list_len   = 0;
  deque_res_t pending_q [$];
  int         mismatches = 0;
  int         cycles     = 0;
  bit         hold_req   = 1'b0;
  int         burst_left = 0;
  bit         filling    = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_deque dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .new_key     (new_key),
    .slot        (slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .removed_key (removed_key),
    .entry_count (entry_count),
    .empty_error (empty_error),
    .full_error  (full_error)
  );

  // apply one transaction to the predicted list and return its result
  function automatic deque_res_t deque_apply(input logic [OPCODE_W-1:0] op, input key_t k,
                                             input logic [SLOT_W-1:0] s);
    deque_res_t r;
    int         pos;
    int         sl;
    r   = '0;
    sl  = int'(s);
    pos = 0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        if (list_len >= CAPACITY) begin
          // full: dropped, list untouched
          r.full_err = 1'b1;
        end else begin
          if (op == OP_PUSH_FRONT) pos = 0;
          else if (op == OP_PUSH_BACK || sl >= list_len) pos = list_len;
          else pos = sl;
          for (int i = list_len; i > pos; i--) list_keys[i] = list_keys[i-1];
          list_keys[pos] = k;
          list_len++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
        if (list_len == 0) begin
          r.empty_err = 1'b1;
        end else begin
          // slot 0 is the front, anything at or past the last entry is the back
          if (op == OP_POP_FRONT || (op == OP_REMOVE_AT && sl == 0)) pos = 0;
          else if (op == OP_POP_BACK || sl >= list_len - 1) pos = list_len - 1;
          else pos = sl;
          r.key = list_keys[pos];
          for (int i = pos; i < list_len - 1; i++) list_keys[i] = list_keys[i+1];
          list_len--;
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = COUNT_OUT_W'(list_len);
    return r;
  endfunction

  // offer one transaction and hold it until accepted, then log the expectation
  task automatic send_txn(input logic [OPCODE_W-1:0] op, input key_t k,
                          input logic [SLOT_W-1:0] s, input logic fixed,
                          input deque_res_t fixed_res);
    deque_res_t r;
    in_valid <= 1'b1;
    opcode   <= op;
    new_key  <= k;
    slot     <= s;
    do @(posedge clk); while (in_stall);
    r = deque_apply(op, k, s);
    pending_q.push_back(fixed ? fixed_res : r);
  endtask

  // sender bursts: random run lengths separated by random gaps, some gapless
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(0, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  // stimulus
  initial begin
    logic [OPCODE_W-1:0] op;
    key_t                k;
    logic [SLOT_W-1:0]   s;
    int                  roll;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int row = 0; row < DIR_ROWS; row++) begin
      for (int rep = 0; rep < DIR_TAB[row].reps; rep++) begin
        send_txn(DIR_TAB[row].op, DIR_TAB[row].key + key_t'(rep), DIR_TAB[row].slot,
                 DIR_TAB[row].fixed, DIR_TAB[row].res);
        pace();
      end
    end

    // random fill/drain sweeps: the trend swings between full and empty
    for (int n = 0; n < RANDOM_TXNS; n++) begin
      if (filling && list_len == CAPACITY && $urandom_range(0, 5) == 0) filling = 1'b0;
      if (!filling && list_len == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      if ($urandom_range(0, 199) == 0) filling = !filling;

      roll = $urandom_range(0, 99);
      if (roll < 2) op = OP_CLEAR;
      else if (roll < 4) op = OP_NOP;
      else if ((roll < 74) == filling) op = INSERT_OPS[$urandom_range(0, 2)];
      else op = REMOVE_OPS[$urandom_range(0, 2)];

      // slots mostly near the live range, sometimes anywhere, sometimes the ends
      roll = $urandom_range(0, 9);
      if (roll < 7) s = SLOT_W'($urandom_range(0, list_len + 1));
      else if (roll < 9) s = SLOT_W'($urandom_range(0, 255));
      else if ($urandom_range(0, 2) == 0) s = '0;
      else if (list_len > 0 && $urandom_range(0, 1) == 0) s = SLOT_W'(list_len - 1);
      else s = '1;

      k = ($urandom_range(0, 4) == 0) ? EDGE_KEYS[$urandom_range(0, 3)] : key_t'($urandom);

      send_txn(op, k, s, 1'b0, ZERO_RES);
      // long receiver hold-off while the sender keeps pushing
      if (n == HOLD_AT_A || n == HOLD_AT_B) hold_req = 1'b1;
      if (n == DRAIN_AT) wait_drained();
      else pace();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("positional_deque regression: pass");
    end else begin
      $display("positional_deque regression: fail");
    end
    $finish;
  end

  // receiver: stall modes change per segment, hold-off counted here
  initial begin
    int mode;
    int seg;
    int hold_left;
    bit stall;
    hold_left = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 60);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_left = HOLD_CYCLES;
          hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
          stall = 1'b1;
          hold_left--;
        end else begin
          case (mode)
            0: stall = 1'b0;
            1: stall = ($urandom_range(0, 3) == 0);
            2: stall = ($urandom_range(0, 1) == 1);
            default: stall = ($urandom_range(0, 7) != 0);
          endcase
        end
        out_stall <= stall;
      end
    end
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    deque_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: key %0d count %0d empty %0b full %0b",
                   removed_key, entry_count, empty_error, full_error);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (removed_key !== want.key || entry_count !== want.count ||
            empty_error !== want.empty_err || full_error !== want.full_err) begin
          if (mismatches < MAX_REPORTS)
            $display({"mismatch: exp key %0d count %0d empty %0b full %0b, ",
                      "got key %0d count %0d empty %0b full %0b"},
                     want.key, want.count, want.empty_err, want.full_err,
                     removed_key, entry_count, empty_error, full_error);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("positional_deque regression: fail");
      $finish;
    end
  end

endmodule
